// ----- design/periodic_timer_bank_top_assert.svh -----
// Assertion macros used by the top module of the timer bank.
`ifndef PERIODIC_TIMER_BANK_TOP_ASSERT_SVH
`define PERIODIC_TIMER_BANK_TOP_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define PTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define PTB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- design/ptb_pkg.sv -----
// Package with the field widths, command codes and shared types of the timer bank.
package ptb_pkg;

  localparam int CmdW    = 2;
  localparam int SlotW   = 4;
  localparam int PeriodW = 16;
  localparam int MaskW   = 16;

  typedef enum logic [CmdW-1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdTick   = 2'd2
  } cmd_e;

  // Command context handed to the update unit for the slot at the ring head.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            match;
  } ptb_ctrl_t;

  // What the update unit reports for the slot at the ring head.
  typedef struct packed {
    logic ok;
    logic expired;
  } ptb_stat_t;

endpackage

// ----- design/ptb_if.sv -----
// Valid/ready channel interfaces for the command words and the result words.
interface ptb_in_if;
  import ptb_pkg::*;

  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic [SlotW-1:0]   slot;
  logic [PeriodW-1:0] period;

  modport source (output valid, output cmd, output slot, output period, input ready);
  modport sink   (input valid, input cmd, input slot, input period, output ready);
endinterface

interface ptb_out_if;
  import ptb_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [MaskW-1:0] expired_mask;

  modport source (output valid, output ok, output expired_mask, input ready);
  modport sink   (input valid, input ok, input expired_mask, output ready);
endinterface

// ----- design/periodic_timer_bank_top.sv -----
// Top level of the periodic timer bank: ring of timer cells, sequencer and result register.
//
// The bank holds NUM_TIMERS periodic countdown timers in a ring of cells. Every command
// word (add, remove or tick) is served by one full turn of the ring: on each step of
// the turn the timer at the ring head passes through a single update unit and moves on
// to the tail, so after the turn every timer is back in its own cell. A command word is
// taken only when no turn is running, so the next word waits until the ring turn of the
// last one is through, since all timers share the single update unit. The result word
// is held in an output register; a new command is taken while a result still waits,
// but its turn does not finish until that result has left. Add arms an idle slot (a
// zero period counts as one) and returns ok; remove disarms an armed slot and returns
// ok; a tick counts down every armed timer, reloads the ones that reach zero and flags
// them in expired_mask (slots sixteen and above are not shown). All timers are idle
// after reset, with no start-up pass.
module periodic_timer_bank_top #(
  parameter int NUM_TIMERS  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  ptb_in_if.sink          in_i,
  ptb_out_if.source       out_o
);
  import ptb_pkg::*;

  `include "periodic_timer_bank_top_assert.svh"

  localparam int IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CmpW = (IdxW > SlotW) ? IdxW : SlotW;

  // Ring storage, one cell per timer.
  logic                   cell_active    [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cell_period    [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] cell_remaining [NUM_TIMERS];

  // Update unit outputs, fed back into the tail cell.
  logic                   head_active;
  logic [COUNT_WIDTH-1:0] head_period;
  logic [COUNT_WIDTH-1:0] head_remaining;
  ptb_ctrl_t              ctrl;
  ptb_stat_t              stat;

  // Sequencer and the latched command word.
  logic               busy_q, busy_d;
  logic [IdxW-1:0]    step_q, step_d;
  logic [CmdW-1:0]    cmd_q;
  logic [SlotW-1:0]   slot_q;
  logic [PeriodW-1:0] period_q;
  logic               last_step;
  logic               advance;
  logic               accept;

  // Running result of the current turn and the output register.
  logic             acc_ok_q, acc_ok_d;
  logic [MaskW-1:0] acc_mask_q, acc_mask_d;
  logic             out_valid_q, out_valid_d;
  logic             out_ok_q;
  logic [MaskW-1:0] out_mask_q;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = !busy_q;
  assign last_step = (step_q == IdxW'(NUM_TIMERS - 1));

  // The final step of a turn writes the output register, so it waits until that
  // register is free or is being emptied in this cycle.
  assign advance = busy_q && (!last_step || !out_valid_q || out_o.ready);

  // The timer at the head of the ring during step k is slot k.
  assign ctrl.cmd   = cmd_q;
  assign ctrl.match = (CmpW'(slot_q) == CmpW'(step_q));

  ptb_head #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_head (
    .ctrl_i       (ctrl),
    .new_period_i (period_q),
    .active_i     (cell_active[0]),
    .period_i     (cell_period[0]),
    .remaining_i  (cell_remaining[0]),
    .active_o     (head_active),
    .period_o     (head_period),
    .remaining_o  (head_remaining),
    .stat_o       (stat)
  );

  // Each cell takes the contents of its neighbor; the tail takes the updated head.
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic                   nxt_active;
    logic [COUNT_WIDTH-1:0] nxt_period;
    logic [COUNT_WIDTH-1:0] nxt_remaining;

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign nxt_active    = head_active;
      assign nxt_period    = head_period;
      assign nxt_remaining = head_remaining;
    end else begin : g_body
      assign nxt_active    = cell_active[i+1];
      assign nxt_period    = cell_period[i+1];
      assign nxt_remaining = cell_remaining[i+1];
    end

    ptb_cell #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (advance),
      .active_i    (nxt_active),
      .period_i    (nxt_period),
      .remaining_i (nxt_remaining),
      .active_o    (cell_active[i]),
      .period_o    (cell_period[i]),
      .remaining_o (cell_remaining[i])
    );
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    acc_ok_d    = acc_ok_q;
    acc_mask_d  = acc_mask_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      busy_d     = 1'b1;
      step_d     = '0;
      acc_ok_d   = 1'b0;
      acc_mask_d = '0;
    end else if (advance) begin
      // Expiry bits of slots beyond the mask width shift out and are dropped.
      acc_ok_d   = acc_ok_q | stat.ok;
      acc_mask_d = acc_mask_q | (MaskW'(stat.expired) << step_q);
      if (last_step) begin
        busy_d      = 1'b0;
        step_d      = '0;
        out_valid_d = 1'b1;
      end else begin
        step_d = step_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_ok_q   <= acc_ok_d;
    acc_mask_q <= acc_mask_d;
    if (accept) begin
      cmd_q    <= in_i.cmd;
      slot_q   <= in_i.slot;
      period_q <= in_i.period;
    end
    if (advance && last_step) begin
      out_ok_q   <= acc_ok_d;
      out_mask_q <= acc_mask_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.ok           = out_ok_q;
  assign out_o.expired_mask = out_mask_q;

  // A taken command word always starts a ring turn.
  `PTB_ASSERT_NEXT(a_accept_starts_turn, accept, busy_q && (step_q == '0), "turn did not start")

  // A result only appears at the end of a ring turn.
  `PTB_ASSERT(a_result_from_turn, $rose(out_valid_q) |-> $past(busy_q && last_step), "stray result")

  // The step counter rests at zero between turns.
  `PTB_ASSERT(a_step_idle_zero, !busy_q |-> (step_q == '0), "step counter not at rest")

  // A result word never reports success and expiries together.
  `PTB_ASSERT(a_ok_xor_mask, out_valid_q |-> !(out_ok_q && (out_mask_q != '0)), "ok with expiries")

endmodule

// ----- design/ptb_cell.sv -----
// One ring cell that holds the state of a single timer and passes it on when the ring turns.
module ptb_cell #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic                   active_i,
  input  logic [COUNT_WIDTH-1:0] period_i,
  input  logic [COUNT_WIDTH-1:0] remaining_i,
  output logic                   active_o,
  output logic [COUNT_WIDTH-1:0] period_o,
  output logic [COUNT_WIDTH-1:0] remaining_o
);

  logic                   active_q;
  logic [COUNT_WIDTH-1:0] period_q;
  logic [COUNT_WIDTH-1:0] remaining_q;

  // Only the armed flag needs a reset; the counts are written by an add first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (shift_i) begin
      active_q <= active_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      period_q    <= period_i;
      remaining_q <= remaining_i;
    end
  end

  assign active_o    = active_q;
  assign period_o    = period_q;
  assign remaining_o = remaining_q;

endmodule

// ----- design/ptb_head.sv -----
// Update unit that applies the current command to the timer at the head of the ring.
module ptb_head #(
  parameter int COUNT_WIDTH = 16
) (
  input  ptb_pkg::ptb_ctrl_t              ctrl_i,
  input  logic [ptb_pkg::PeriodW-1:0]     new_period_i,
  input  logic                            active_i,
  input  logic [COUNT_WIDTH-1:0]          period_i,
  input  logic [COUNT_WIDTH-1:0]          remaining_i,
  output logic                            active_o,
  output logic [COUNT_WIDTH-1:0]          period_o,
  output logic [COUNT_WIDTH-1:0]          remaining_o,
  output ptb_pkg::ptb_stat_t              stat_o
);
  import ptb_pkg::*;

  logic [COUNT_WIDTH-1:0] load_val;
  logic [COUNT_WIDTH-1:0] dec_val;

  // A zero period behaves as a period of one tick.
  always_comb begin
    load_val = COUNT_WIDTH'(new_period_i);
    if (load_val == '0) begin
      load_val = COUNT_WIDTH'(1);
    end
  end

  assign dec_val = remaining_i - COUNT_WIDTH'(1);

  always_comb begin
    active_o       = active_i;
    period_o       = period_i;
    remaining_o    = remaining_i;
    stat_o.ok      = 1'b0;
    stat_o.expired = 1'b0;
    case (ctrl_i.cmd)
      CmdAdd: begin
        if (ctrl_i.match && !active_i) begin
          active_o    = 1'b1;
          period_o    = load_val;
          remaining_o = load_val;
          stat_o.ok   = 1'b1;
        end
      end
      CmdRemove: begin
        if (ctrl_i.match && active_i) begin
          active_o  = 1'b0;
          stat_o.ok = 1'b1;
        end
      end
      CmdTick: begin
        if (active_i) begin
          if (dec_val == '0) begin
            remaining_o    = period_i;
            stat_o.expired = 1'b1;
          end else begin
            remaining_o = dec_val;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
